>>> sv/tpac_pkg.sv
// Package: shared types and constants for the two-piece affine alignment cell.
`default_nettype none

package tpac_pkg;

   // Field and datapath widths
   localparam int SYM_BITS       = 8;
   localparam int FIELD_BITS     = 16;
   localparam int CFG_BITS       = 11;
   localparam int CFG_SUM_BITS   = CFG_BITS + 1;
   localparam int SUM_BITS       = FIELD_BITS + 2;
   localparam int WIDE_BITS      = 33;
   localparam int CSR_INDEX_BITS = 3;

   // Register indexes of the configuration port
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_GAP_OPEN        = 3'd0,
      CSR_GAP_EXTEND      = 3'd1,
      CSR_LONG_GAP_OPEN   = 3'd2,
      CSR_LONG_GAP_EXTEND = 3'd3,
      CSR_MATCH_SCORE     = 3'd4,
      CSR_MISMATCH_SCORE  = 3'd5
   } csr_index_type;

   // Register reset values
   localparam logic signed [CFG_BITS-1:0] GAP_OPEN_RESET        = -11'sd4;
   localparam logic signed [CFG_BITS-1:0] GAP_EXTEND_RESET      = -11'sd2;
   localparam logic signed [CFG_BITS-1:0] LONG_GAP_OPEN_RESET   = -11'sd24;
   localparam logic signed [CFG_BITS-1:0] LONG_GAP_EXTEND_RESET = -11'sd1;
   localparam logic signed [CFG_BITS-1:0] MATCH_SCORE_RESET     = 11'sd2;
   localparam logic signed [CFG_BITS-1:0] MISMATCH_SCORE_RESET  = -11'sd4;

   // Winning candidate of the main layer
   typedef enum logic [2:0] {
      DIR_MAIN        = 3'd0,
      DIR_INSERT      = 3'd1,
      DIR_DELETE      = 3'd2,
      DIR_LONG_INSERT = 3'd3,
      DIR_LONG_DELETE = 3'd4
   } dir_type;

   // Input item
   typedef struct packed {
      logic [SYM_BITS-1:0]          query_symbol;
      logic [SYM_BITS-1:0]          reference_symbol;
      logic signed [FIELD_BITS-1:0] left_main;
      logic signed [FIELD_BITS-1:0] left_insert;
      logic signed [FIELD_BITS-1:0] left_long_insert;
      logic signed [FIELD_BITS-1:0] up_main;
      logic signed [FIELD_BITS-1:0] up_delete;
      logic signed [FIELD_BITS-1:0] up_long_delete;
      logic signed [FIELD_BITS-1:0] diag_main;
   } req_type;

   // Result item
   typedef struct packed {
      logic signed [FIELD_BITS-1:0] insert_score;
      logic signed [FIELD_BITS-1:0] best_score;
      logic signed [FIELD_BITS-1:0] delete_score;
      logic signed [FIELD_BITS-1:0] long_insert_score;
      logic signed [FIELD_BITS-1:0] long_delete_score;
      dir_type                      direction;
      logic                         insert_extended;
      logic                         delete_extended;
      logic                         long_insert_extended;
      logic                         long_delete_extended;
   } rsp_type;

   // Sign-extend a neighbour score to the sum width
   function automatic logic signed [SUM_BITS-1:0] ext_field(
      input logic signed [FIELD_BITS-1:0] v);
      ext_field = $signed({{(SUM_BITS-FIELD_BITS){v[FIELD_BITS-1]}}, v});
   endfunction

   // Sign-extend a register value to the sum width
   function automatic logic signed [SUM_BITS-1:0] ext_cfg(
      input logic signed [CFG_BITS-1:0] v);
      ext_cfg = $signed({{(SUM_BITS-CFG_BITS){v[CFG_BITS-1]}}, v});
   endfunction

   // Sign-extend a sum of two registers to the sum width
   function automatic logic signed [SUM_BITS-1:0] ext_cfg_sum(
      input logic signed [CFG_SUM_BITS-1:0] v);
      ext_cfg_sum = $signed({{(SUM_BITS-CFG_SUM_BITS){v[CFG_SUM_BITS-1]}}, v});
   endfunction

endpackage

`default_nettype wire

>>> sv/two_piece_affine_alignment_cell.sv
// Top level: pipelined two-piece affine gap alignment cell with its register file.
// An accepted item reaches rsp_valid through the stage 1 to stage 4 registers.
// Throughput: one item per cycle; the four stages advance together and hold
// while the output stage carries a result that rsp_stall keeps.
// Reset: synchronous, active high; clears all stage valid bits and loads the
// registers with their reset values. csr_ready is always high.
`default_nettype none

module two_piece_affine_alignment_cell
   import tpac_pkg::*;
#(
   parameter int SCORE_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   // input channel
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire req_type                   req_data,
   // result channel
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output rsp_type                        rsp_data,
   // configuration channel
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CFG_BITS-1:0]       csr_data
);

   // Clamp bounds of the score range
   localparam logic signed [WIDE_BITS-1:0] ScoreHi =
      (WIDE_BITS'(1) <<< (SCORE_BITS - 1)) - WIDE_BITS'(1);
   localparam logic signed [WIDE_BITS-1:0] ScoreLo = -ScoreHi - WIDE_BITS'(1);

   // Saturate an exact sum to the score range
   function automatic logic signed [SUM_BITS-1:0] clamp_score(
      input logic signed [SUM_BITS-1:0] v);
      logic signed [WIDE_BITS-1:0] w;
      w = $signed({{(WIDE_BITS-SUM_BITS){v[SUM_BITS-1]}}, v});
      if (w > ScoreHi) begin
         clamp_score = $signed(ScoreHi[SUM_BITS-1:0]);
      end else if (w < ScoreLo) begin
         clamp_score = $signed(ScoreLo[SUM_BITS-1:0]);
      end else begin
         clamp_score = v;
      end
   endfunction

   // ---------------- configuration registers ----------------
   logic signed [CFG_BITS-1:0] gap_open_ff, gap_extend_ff;
   logic signed [CFG_BITS-1:0] long_gap_open_ff, long_gap_extend_ff;
   logic signed [CFG_BITS-1:0] match_score_ff, mismatch_score_ff;
   logic                       csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Write one register; unused indexes drop the write
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_open_ff        <= GAP_OPEN_RESET;
         gap_extend_ff      <= GAP_EXTEND_RESET;
         long_gap_open_ff   <= LONG_GAP_OPEN_RESET;
         long_gap_extend_ff <= LONG_GAP_EXTEND_RESET;
         match_score_ff     <= MATCH_SCORE_RESET;
         mismatch_score_ff  <= MISMATCH_SCORE_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_GAP_OPEN:        gap_open_ff        <= $signed(csr_data);
            CSR_GAP_EXTEND:      gap_extend_ff      <= $signed(csr_data);
            CSR_LONG_GAP_OPEN:   long_gap_open_ff   <= $signed(csr_data);
            CSR_LONG_GAP_EXTEND: long_gap_extend_ff <= $signed(csr_data);
            CSR_MATCH_SCORE:     match_score_ff     <= $signed(csr_data);
            CSR_MISMATCH_SCORE:  mismatch_score_ff  <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // Open cost of each gap kind: open plus first extend
   logic signed [CFG_SUM_BITS-1:0] short_open_total, long_open_total;
   assign short_open_total = $signed({gap_open_ff[CFG_BITS-1], gap_open_ff})
                           + $signed({gap_extend_ff[CFG_BITS-1], gap_extend_ff});
   assign long_open_total  = $signed({long_gap_open_ff[CFG_BITS-1], long_gap_open_ff})
                           + $signed({long_gap_extend_ff[CFG_BITS-1], long_gap_extend_ff});

   // ---------------- pipeline control ----------------
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff;
   logic advance;

   // Hold every stage while the result waits
   assign advance   = !(s4_v_ff && rsp_stall);
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else if (advance) begin
         s1_v_ff <= req_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   // ---------------- stage 1: exact candidate sums ----------------
   logic signed [SUM_BITS-1:0] s1_ins_open_ff, s1_ins_ext_ff;
   logic signed [SUM_BITS-1:0] s1_del_open_ff, s1_del_ext_ff;
   logic signed [SUM_BITS-1:0] s1_lins_open_ff, s1_lins_ext_ff;
   logic signed [SUM_BITS-1:0] s1_ldel_open_ff, s1_ldel_ext_ff;
   logic signed [SUM_BITS-1:0] s1_match_ff;
   logic signed [CFG_BITS-1:0] subst_score;

   assign subst_score = (req_data.query_symbol == req_data.reference_symbol)
                      ? match_score_ff : mismatch_score_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ins_open_ff  <= ext_field(req_data.left_main) + ext_cfg_sum(short_open_total);
         s1_ins_ext_ff   <= ext_field(req_data.left_insert) + ext_cfg(gap_extend_ff);
         s1_del_open_ff  <= ext_field(req_data.up_main) + ext_cfg_sum(short_open_total);
         s1_del_ext_ff   <= ext_field(req_data.up_delete) + ext_cfg(gap_extend_ff);
         s1_lins_open_ff <= ext_field(req_data.left_main) + ext_cfg_sum(long_open_total);
         s1_lins_ext_ff  <= ext_field(req_data.left_long_insert)
                          + ext_cfg(long_gap_extend_ff);
         s1_ldel_open_ff <= ext_field(req_data.up_main) + ext_cfg_sum(long_open_total);
         s1_ldel_ext_ff  <= ext_field(req_data.up_long_delete)
                          + ext_cfg(long_gap_extend_ff);
         s1_match_ff     <= ext_field(req_data.diag_main) + ext_cfg(subst_score);
      end
   end

   // ---------------- stage 2: clamp and pick open or extend ----------------
   logic signed [SUM_BITS-1:0] ins_open_c, ins_ext_c, del_open_c, del_ext_c;
   logic signed [SUM_BITS-1:0] lins_open_c, lins_ext_c, ldel_open_c, ldel_ext_c;
   logic signed [SUM_BITS-1:0] s2_ins_ff, s2_del_ff, s2_lins_ff, s2_ldel_ff, s2_match_ff;
   logic                       s2_fi_ff, s2_fd_ff, s2_fli_ff, s2_fld_ff;
   logic                       fi_in, fd_in, fli_in, fld_in;

   always_comb begin
      ins_open_c  = clamp_score(s1_ins_open_ff);
      ins_ext_c   = clamp_score(s1_ins_ext_ff);
      del_open_c  = clamp_score(s1_del_open_ff);
      del_ext_c   = clamp_score(s1_del_ext_ff);
      lins_open_c = clamp_score(s1_lins_open_ff);
      lins_ext_c  = clamp_score(s1_lins_ext_ff);
      ldel_open_c = clamp_score(s1_ldel_open_ff);
      ldel_ext_c  = clamp_score(s1_ldel_ext_ff);
      // a tie keeps open
      fi_in  = ins_open_c < ins_ext_c;
      fd_in  = del_open_c < del_ext_c;
      fli_in = lins_open_c < lins_ext_c;
      fld_in = ldel_open_c < ldel_ext_c;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_ins_ff   <= fi_in  ? ins_ext_c  : ins_open_c;
         s2_del_ff   <= fd_in  ? del_ext_c  : del_open_c;
         s2_lins_ff  <= fli_in ? lins_ext_c : lins_open_c;
         s2_ldel_ff  <= fld_in ? ldel_ext_c : ldel_open_c;
         s2_match_ff <= clamp_score(s1_match_ff);
         s2_fi_ff    <= fi_in;
         s2_fd_ff    <= fd_in;
         s2_fli_ff   <= fli_in;
         s2_fld_ff   <= fld_in;
      end
   end

   // ---------------- stage 3: match against long gaps ----------------
   logic signed [SUM_BITS-1:0] s3_ins_ff, s3_del_ff, s3_lins_ff, s3_ldel_ff, s3_best_ff;
   logic                       s3_fi_ff, s3_fd_ff, s3_fli_ff, s3_fld_ff;
   dir_type                    s3_dir_ff;
   logic signed [SUM_BITS-1:0] best3_a, best3_in;
   dir_type                    dir3_a, dir3_in;

   // A later candidate wins only when strictly greater
   always_comb begin
      best3_a = s2_match_ff;
      dir3_a  = DIR_MAIN;
      if (best3_a < s2_lins_ff) begin
         best3_a = s2_lins_ff;
         dir3_a  = DIR_LONG_INSERT;
      end
      best3_in = best3_a;
      dir3_in  = dir3_a;
      if (best3_a < s2_ldel_ff) begin
         best3_in = s2_ldel_ff;
         dir3_in  = DIR_LONG_DELETE;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_ins_ff  <= s2_ins_ff;
         s3_del_ff  <= s2_del_ff;
         s3_lins_ff <= s2_lins_ff;
         s3_ldel_ff <= s2_ldel_ff;
         s3_best_ff <= best3_in;
         s3_dir_ff  <= dir3_in;
         s3_fi_ff   <= s2_fi_ff;
         s3_fd_ff   <= s2_fd_ff;
         s3_fli_ff  <= s2_fli_ff;
         s3_fld_ff  <= s2_fld_ff;
      end
   end

   // ---------------- stage 4: short gaps and output register ----------------
   logic signed [SUM_BITS-1:0] s4_ins_ff, s4_del_ff, s4_lins_ff, s4_ldel_ff, s4_best_ff;
   logic                       s4_fi_ff, s4_fd_ff, s4_fli_ff, s4_fld_ff;
   dir_type                    s4_dir_ff;
   logic signed [SUM_BITS-1:0] best4_a, best4_in;
   dir_type                    dir4_a, dir4_in;

   always_comb begin
      best4_a = s3_best_ff;
      dir4_a  = s3_dir_ff;
      if (best4_a < s3_ins_ff) begin
         best4_a = s3_ins_ff;
         dir4_a  = DIR_INSERT;
      end
      best4_in = best4_a;
      dir4_in  = dir4_a;
      if (best4_a < s3_del_ff) begin
         best4_in = s3_del_ff;
         dir4_in  = DIR_DELETE;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s4_ins_ff  <= s3_ins_ff;
         s4_del_ff  <= s3_del_ff;
         s4_lins_ff <= s3_lins_ff;
         s4_ldel_ff <= s3_ldel_ff;
         s4_best_ff <= best4_in;
         s4_dir_ff  <= dir4_in;
         s4_fi_ff   <= s3_fi_ff;
         s4_fd_ff   <= s3_fd_ff;
         s4_fli_ff  <= s3_fli_ff;
         s4_fld_ff  <= s3_fld_ff;
      end
   end

   // Drive the result item from the last stage
   assign rsp_valid = s4_v_ff;

   always_comb begin
      rsp_data.insert_score         = s4_ins_ff[FIELD_BITS-1:0];
      rsp_data.best_score           = s4_best_ff[FIELD_BITS-1:0];
      rsp_data.delete_score         = s4_del_ff[FIELD_BITS-1:0];
      rsp_data.long_insert_score    = s4_lins_ff[FIELD_BITS-1:0];
      rsp_data.long_delete_score    = s4_ldel_ff[FIELD_BITS-1:0];
      rsp_data.direction            = s4_dir_ff;
      rsp_data.insert_extended      = s4_fi_ff;
      rsp_data.delete_extended      = s4_fd_ff;
      rsp_data.long_insert_extended = s4_fli_ff;
      rsp_data.long_delete_extended = s4_fld_ff;
   end

   // ---------------- assertions ----------------
   a_accept_fills_stage1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> s1_v_ff)
      else $error("accepted item did not reach stage 1");

   a_stage1_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_v_ff && !advance) |=> (s1_v_ff && $stable(s1_match_ff)))
      else $error("stage 1 changed during a stall");

   a_best_is_max: assert property (@(posedge clock) disable iff (reset)
      s4_v_ff |-> (s4_best_ff >= s4_ins_ff && s4_best_ff >= s4_del_ff &&
                   s4_best_ff >= s4_lins_ff && s4_best_ff >= s4_ldel_ff))
      else $error("best score below a gap layer score");

   a_insert_dir_matches: assert property (@(posedge clock) disable iff (reset)
      (s4_v_ff && s4_dir_ff == DIR_INSERT) |-> (s4_best_ff == s4_ins_ff))
      else $error("insert direction without insert score");

endmodule

`default_nettype wire
